@@ design/gid_pkg.sv @@
// ----------------------------------------------------------------------------
// Island disconnect package
// Shared sizes, register indexes, result codes and the controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package gid_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RC_W  = $clog2(MAX_ROWS + 1);
  localparam int CC_W  = $clog2(MAX_COLS + 1);
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int QW    = ROW_W + COL_W;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     CFG_RESET = CFG_W'(32);

  localparam logic [1:0] DAYS_ZERO = 2'd0;
  localparam logic [1:0] DAYS_ONE  = 2'd1;
  localparam logic [1:0] DAYS_TWO  = 2'd2;

  typedef enum logic [1:0] {
    PS_SCAN,
    PS_CUR_NB,
    PS_TRIAL,
    PS_TRIAL_NB
  } probe_src_e;

  typedef struct packed {
    logic       in_ready;
    probe_src_e probe_src;
    logic       scan_clr;
    logic       scan_adv;
    logic       mark_clr;
    logic       mark_set;
    logic       push;
    logic       pop;
    logic       comp_clr;
    logic       comp_inc;
    logic       land_clr;
    logic       land_inc;
    logic       cur_load;
    logic       k_clr;
    logic       k_inc;
    logic       flag_wr;
    logic       trial_clr;
    logic       trial_adv;
    logic       skip_set;
    logic       skip_off;
    logic       out_load;
    logic [1:0] days;
  } cmd_t;

  typedef struct packed {
    logic       in_last_acc;
    logic       land_eff;
    logic       marked;
    logic       s_last;
    logic       t_last;
    logic       k3;
    logic       k7;
    logic       q_empty;
    logic [1:0] comps;
    logic       land_one;
    logic       all8;
    logic       any4;
    logic       out_busy;
  } sts_t;

  // Neighbor order: west, east, north, south, then the four diagonals.
  function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
    logic signed [1:0] d;
    case (k)
      3'd2, 3'd4, 3'd5: d = -2'sd1;
      3'd3, 3'd6, 3'd7: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd4, 3'd6: d = -2'sd1;
      3'd1, 3'd5, 3'd7: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

@@ design/gid_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gid_ram #(
  parameter int W = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/gid_ctrl.sv @@
// ----------------------------------------------------------------------------
// Island disconnect controller
// Sequences loading, mark clearing, component search and trial removals.
// ----------------------------------------------------------------------------
module gid_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gid_pkg::sts_t sts_i,
  output gid_pkg::cmd_t cmd_o
);
  import gid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_SC_RD,
    S_SC_CHK,
    S_POP,
    S_CUR,
    S_NB_RD,
    S_NB_CHK,
    S_DONE,
    S_TR_RD,
    S_TR_CHK,
    S_TN_RD,
    S_TN_CHK,
    S_TR_EVAL,
    S_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] days_q, days_d;
  logic       trial_q, trial_d;

  always_comb begin
    cmd_o           = '0;
    cmd_o.probe_src = PS_SCAN;
    cmd_o.days      = days_q;
    state_d         = state_q;
    days_d          = days_q;
    trial_d         = trial_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_last_acc) begin
          cmd_o.scan_clr = 1'b1;
          cmd_o.skip_off = 1'b1;
          cmd_o.land_clr = 1'b1;
          trial_d        = 1'b0;
          state_d        = S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.mark_clr = 1'b1;
        if (sts_i.s_last) begin
          cmd_o.scan_clr = 1'b1;
          cmd_o.comp_clr = 1'b1;
          state_d        = S_SC_RD;
        end else begin
          cmd_o.scan_adv = 1'b1;
        end
      end
      S_SC_RD: begin
        state_d = S_SC_CHK;
      end
      S_SC_CHK: begin
        cmd_o.land_inc = !trial_q;
        if (sts_i.land_eff && !sts_i.marked) begin
          cmd_o.comp_inc = 1'b1;
          if (sts_i.comps == 2'd1) begin
            state_d = S_DONE;
          end else begin
            cmd_o.mark_set = 1'b1;
            cmd_o.push     = 1'b1;
            state_d        = S_POP;
          end
        end else if (sts_i.s_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_SC_RD;
        end
      end
      S_POP: begin
        if (!sts_i.q_empty) begin
          cmd_o.pop = 1'b1;
          state_d   = S_CUR;
        end else if (sts_i.s_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_SC_RD;
        end
      end
      S_CUR: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.k_clr    = 1'b1;
        state_d        = S_NB_RD;
      end
      S_NB_RD: begin
        cmd_o.probe_src = PS_CUR_NB;
        state_d         = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (sts_i.land_eff && !sts_i.marked) begin
          cmd_o.mark_set = 1'b1;
          cmd_o.push     = 1'b1;
        end
        cmd_o.k_inc = 1'b1;
        state_d     = sts_i.k3 ? S_POP : S_NB_RD;
      end
      S_DONE: begin
        if (!trial_q) begin
          if (sts_i.comps != 2'd1) begin
            days_d  = DAYS_ZERO;
            state_d = S_OUT;
          end else if (sts_i.land_one) begin
            days_d  = DAYS_ONE;
            state_d = S_OUT;
          end else begin
            cmd_o.trial_clr = 1'b1;
            state_d         = S_TR_RD;
          end
        end else begin
          cmd_o.skip_off = 1'b1;
          if (sts_i.comps != 2'd1) begin
            days_d  = DAYS_ONE;
            state_d = S_OUT;
          end else if (sts_i.t_last) begin
            days_d  = DAYS_TWO;
            state_d = S_OUT;
          end else begin
            cmd_o.trial_adv = 1'b1;
            state_d         = S_TR_RD;
          end
        end
      end
      S_TR_RD: begin
        cmd_o.probe_src = PS_TRIAL;
        state_d         = S_TR_CHK;
      end
      S_TR_CHK: begin
        if (sts_i.land_eff) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_TN_RD;
        end else if (sts_i.t_last) begin
          days_d  = DAYS_TWO;
          state_d = S_OUT;
        end else begin
          cmd_o.trial_adv = 1'b1;
          state_d         = S_TR_RD;
        end
      end
      S_TN_RD: begin
        cmd_o.probe_src = PS_TRIAL_NB;
        state_d         = S_TN_CHK;
      end
      S_TN_CHK: begin
        cmd_o.flag_wr = 1'b1;
        cmd_o.k_inc   = 1'b1;
        state_d       = sts_i.k7 ? S_TR_EVAL : S_TN_RD;
      end
      S_TR_EVAL: begin
        if (sts_i.all8 || !sts_i.any4) begin
          if (sts_i.t_last) begin
            days_d  = DAYS_TWO;
            state_d = S_OUT;
          end else begin
            cmd_o.trial_adv = 1'b1;
            state_d         = S_TR_RD;
          end
        end else begin
          cmd_o.skip_set = 1'b1;
          cmd_o.scan_clr = 1'b1;
          trial_d        = 1'b1;
          state_d        = S_CLR;
        end
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      days_q  <= DAYS_ZERO;
      trial_q <= 1'b0;
    end else begin
      state_q <= state_d;
      days_q  <= days_d;
      trial_q <= trial_d;
    end
  end

endmodule

@@ design/gid_dp.sv @@
// ----------------------------------------------------------------------------
// Island disconnect datapath
// Grid, mark and search queue memories, scan counters, cell probe and
// configuration and result registers.
// ----------------------------------------------------------------------------
module gid_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gid_pkg::cmd_t                  cmd_i,
  output gid_pkg::sts_t                  sts_o,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cell_is_land_i,
  input  logic                           last_cell_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     days_needed_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gid_pkg::CFG_W-1:0]      cfg_data_i
);
  import gid_pkg::*;

  logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [RC_W-1:0]  rows_used;
  logic [CC_W-1:0]  cols_used;
  logic [CNT_W-1:0] total;

  logic [CNT_W-1:0] load_pos_q, eval_len_q, pos_after;
  logic             accept, land_we;

  logic [ROW_W-1:0] s_r_q, t_r_q, cur_r_q, prr_q;
  logic [COL_W-1:0] s_c_q, t_c_q, cur_c_q, pcc_q;
  logic [IDX_W-1:0] t_idx_q, skip_q, idx_q;
  logic             skip_en_q, inb_q;
  logic [CNT_W-1:0] head_q, tail_q;
  logic [1:0]       comps_q, land_cnt_q;
  logic [2:0]       k_q;
  logic [7:0]       flags_q;
  logic             out_valid_q;
  logic [1:0]       days_q;

  logic                    s_c_end, s_r_end, t_c_end, t_r_end;
  logic [ROW_W-1:0]        br;
  logic [COL_W-1:0]        bc;
  logic signed [1:0]       dr, dc;
  logic signed [ROW_W+1:0] pr_s;
  logic signed [COL_W+1:0] pc_s;
  logic                    inb;
  logic [CNT_W-1:0]        lin;
  logic [IDX_W-1:0]        probe_idx;

  logic             land_rd, mark_rd, land_eff;
  logic [QW-1:0]    q_rd;
  logic             mark_we;
  logic [IDX_W-1:0] mark_waddr;

  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_used = RC_W'(1);
    end else if (32'(rows_cfg_q) > MAX_ROWS) begin
      rows_used = RC_W'(MAX_ROWS);
    end else begin
      rows_used = RC_W'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      cols_used = CC_W'(1);
    end else if (32'(cols_cfg_q) > MAX_COLS) begin
      cols_used = CC_W'(MAX_COLS);
    end else begin
      cols_used = CC_W'(cols_cfg_q);
    end
  end

  assign total     = CNT_W'(rows_used) * CNT_W'(cols_used);
  assign in_ready_o  = cmd_i.in_ready;
  assign cfg_ready_o = 1'b1;
  assign accept    = in_valid_i && cmd_i.in_ready;
  assign land_we   = accept && (load_pos_q < total);
  assign pos_after = land_we ? load_pos_q + CNT_W'(1) : load_pos_q;

  assign s_c_end = ((COL_W+1)'(s_c_q) + (COL_W+1)'(1)) == (COL_W+1)'(cols_used);
  assign s_r_end = ((ROW_W+1)'(s_r_q) + (ROW_W+1)'(1)) == (ROW_W+1)'(rows_used);
  assign t_c_end = ((COL_W+1)'(t_c_q) + (COL_W+1)'(1)) == (COL_W+1)'(cols_used);
  assign t_r_end = ((ROW_W+1)'(t_r_q) + (ROW_W+1)'(1)) == (ROW_W+1)'(rows_used);

  always_comb begin
    case (cmd_i.probe_src)
      PS_CUR_NB: begin
        br = cur_r_q;
        bc = cur_c_q;
        dr = nb_dr(k_q);
        dc = nb_dc(k_q);
      end
      PS_TRIAL: begin
        br = t_r_q;
        bc = t_c_q;
        dr = 2'sd0;
        dc = 2'sd0;
      end
      PS_TRIAL_NB: begin
        br = t_r_q;
        bc = t_c_q;
        dr = nb_dr(k_q);
        dc = nb_dc(k_q);
      end
      default: begin
        br = s_r_q;
        bc = s_c_q;
        dr = 2'sd0;
        dc = 2'sd0;
      end
    endcase
    pr_s = $signed((ROW_W+2)'(br)) + (ROW_W+2)'(dr);
    pc_s = $signed((COL_W+2)'(bc)) + (COL_W+2)'(dc);
    inb  = !pr_s[ROW_W+1] && (pr_s < $signed((ROW_W+2)'(rows_used))) &&
           !pc_s[COL_W+1] && (pc_s < $signed((COL_W+2)'(cols_used)));
    lin  = CNT_W'(pr_s[ROW_W-1:0]) * CNT_W'(cols_used) + CNT_W'(pc_s[COL_W-1:0]);
  end

  assign probe_idx = lin[IDX_W-1:0];

  assign land_eff = inb_q && (CNT_W'(idx_q) < eval_len_q) &&
                    !(skip_en_q && (idx_q == skip_q)) && land_rd;

  assign mark_we    = cmd_i.mark_clr || cmd_i.mark_set;
  assign mark_waddr = cmd_i.mark_clr ? probe_idx : idx_q;

  gid_ram #(.W(1), .DEPTH(CELLS)) u_land_ram (
    .clk_i   (clk_i),
    .we_i    (land_we),
    .waddr_i (load_pos_q[IDX_W-1:0]),
    .wdata_i (cell_is_land_i),
    .raddr_i (probe_idx),
    .rdata_o (land_rd)
  );

  gid_ram #(.W(1), .DEPTH(CELLS)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (cmd_i.mark_set),
    .raddr_i (probe_idx),
    .rdata_o (mark_rd)
  );

  gid_ram #(.W(QW), .DEPTH(CELLS)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (tail_q[IDX_W-1:0]),
    .wdata_i ({prr_q, pcc_q}),
    .raddr_i (head_q[IDX_W-1:0]),
    .rdata_o (q_rd)
  );

  always_ff @(posedge clk_i) begin
    inb_q <= inb;
    idx_q <= probe_idx;
    prr_q <= pr_s[ROW_W-1:0];
    pcc_q <= pc_s[COL_W-1:0];
    if (cmd_i.cur_load) begin
      cur_r_q <= q_rd[QW-1:COL_W];
      cur_c_q <= q_rd[COL_W-1:0];
    end
    if (cmd_i.flag_wr) begin
      flags_q[k_q] <= land_eff;
    end
    if (cmd_i.skip_set) begin
      skip_q <= t_idx_q;
    end
    if (cmd_i.out_load) begin
      days_q <= cmd_i.days;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q  <= CFG_RESET;
      cols_cfg_q  <= CFG_RESET;
      load_pos_q  <= '0;
      eval_len_q  <= '0;
      s_r_q       <= '0;
      s_c_q       <= '0;
      t_r_q       <= '0;
      t_c_q       <= '0;
      t_idx_q     <= '0;
      skip_en_q   <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      comps_q     <= '0;
      land_cnt_q  <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ROWS: rows_cfg_q <= cfg_data_i;
          REG_COLS: cols_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        if (last_cell_i) begin
          eval_len_q <= pos_after;
          load_pos_q <= '0;
        end else begin
          load_pos_q <= pos_after;
        end
      end
      if (cmd_i.scan_clr) begin
        s_r_q <= '0;
        s_c_q <= '0;
      end else if (cmd_i.scan_adv) begin
        if (s_c_end) begin
          s_c_q <= '0;
          s_r_q <= s_r_q + ROW_W'(1);
        end else begin
          s_c_q <= s_c_q + COL_W'(1);
        end
      end
      if (cmd_i.trial_clr) begin
        t_r_q   <= '0;
        t_c_q   <= '0;
        t_idx_q <= '0;
      end else if (cmd_i.trial_adv) begin
        t_idx_q <= t_idx_q + IDX_W'(1);
        if (t_c_end) begin
          t_c_q <= '0;
          t_r_q <= t_r_q + ROW_W'(1);
        end else begin
          t_c_q <= t_c_q + COL_W'(1);
        end
      end
      if (cmd_i.skip_set) begin
        skip_en_q <= 1'b1;
      end else if (cmd_i.skip_off) begin
        skip_en_q <= 1'b0;
      end
      if (cmd_i.comp_clr) begin
        comps_q <= '0;
        head_q  <= '0;
        tail_q  <= '0;
      end else begin
        if (cmd_i.comp_inc && comps_q != 2'd2) begin
          comps_q <= comps_q + 2'd1;
        end
        if (cmd_i.push) begin
          tail_q <= tail_q + CNT_W'(1);
        end
        if (cmd_i.pop) begin
          head_q <= head_q + CNT_W'(1);
        end
      end
      if (cmd_i.land_clr) begin
        land_cnt_q <= '0;
      end else if (cmd_i.land_inc && land_eff && land_cnt_q != 2'd2) begin
        land_cnt_q <= land_cnt_q + 2'd1;
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 3'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign days_needed_o = days_q;

  always_comb begin
    sts_o             = '0;
    sts_o.in_last_acc = accept && last_cell_i;
    sts_o.land_eff    = land_eff;
    sts_o.marked      = mark_rd;
    sts_o.s_last      = s_r_end && s_c_end;
    sts_o.t_last      = t_r_end && t_c_end;
    sts_o.k3          = (k_q == 3'd3);
    sts_o.k7          = (k_q == 3'd7);
    sts_o.q_empty     = (head_q == tail_q);
    sts_o.comps       = comps_q;
    sts_o.land_one    = (land_cnt_q == 2'd1);
    sts_o.all8        = &flags_q;
    sts_o.any4        = |flags_q[3:0];
    sts_o.out_busy    = out_valid_q;
  end

endmodule

@@ design/grid_island_disconnect_days.sv @@
// ----------------------------------------------------------------------------
// Grid island disconnect days
// Loads a land/water grid cell by cell and reports how many land cells must
// be removed to split its single island.
// ----------------------------------------------------------------------------
// The input channel takes one grid cell per transfer in row-major order; a
// transfer with last_cell_i set ends the grid and starts the evaluation.
// Cells are taken one per cycle while the block is loading. The evaluation
// then runs a clear pass, a scan and a breadth-first search over the
// N = rows * cols cells, with one read port each on the grid, mark and
// queue memories, for each component count. If the first count finds one
// island of more than one land cell, every land cell with a land neighbor
// that is not fully surrounded gets its own trial count until one splits it.
// One result transfer follows each grid on the output channel; it is held
// in an output register until taken, and the block keeps loading the next
// grid meanwhile. A stalled receiver delays the next result and holds off
// new cells. The configuration channel is always ready and should be written
// only while the block is idle. Reset returns to loading at the first cell
// with 32 rows and 32 columns; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module grid_island_disconnect_days (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cell_is_land_i,
  input  logic                          last_cell_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    days_needed_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gid_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gid_pkg::CFG_W-1:0]     cfg_data_i
);
  import gid_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gid_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  gid_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cell_is_land_i (cell_is_land_i),
    .last_cell_i    (last_cell_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .days_needed_o  (days_needed_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

endmodule

@@ tb/sv/tb_grid_island_disconnect_days.sv @@
// ----------------------------------------------------------------------------
// Island disconnect days testbench
// Loads small and occasional full-size grids through the cell channel and
// checks each day count against a local grid evaluator or a typed value.
// A short table of hand-picked grids comes first, then random grids. The
// bench covers register saturation, early and surplus cells, and a stalled receiver.
// ----------------------------------------------------------------------------
module tb_grid_island_disconnect_days;
  import gid_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int TAIL_CYCLES    = 50;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              cell_is_land = 1'b0;
  logic              last_cell = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        days_needed;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  always #5 clk_i = ~clk_i;

  grid_island_disconnect_days dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cell_is_land_i(cell_is_land),
    .last_cell_i   (last_cell),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .days_needed_o (days_needed),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Local copy of the grid state.
  bit         grid_land [CELLS];
  int         fill_pos;
  logic [CFG_W-1:0] rows_reg = CFG_RESET;
  logic [CFG_W-1:0] cols_reg = CFG_RESET;

  logic [1:0] days_pending[$];
  int         mismatches = 0;
  int         cells_sent = 0;
  bit         no_idle = 1'b0;
  int         quiet_cycles = 0;
  bit         use_typed = 1'b0;
  logic [1:0] typed_days = DAYS_ZERO;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic bit is_land(int idx, int skip);
    if (idx >= fill_pos || idx >= CELLS || idx == skip) return 1'b0;
    return grid_land[idx];
  endfunction

  function automatic bit land_rc(int r, int c, int rows, int cols);
    if (r < 0 || c < 0 || r >= rows || c >= cols) return 1'b0;
    return is_land(r * cols + c, -1);
  endfunction

  // Counts 4-connected components, stopping at two.
  function automatic int island_count(int rows, int cols, int skip);
    bit seen [CELLS];
    int fifo [CELLS];
    int head, tail, cur, r, c, comps;
    comps = 0;
    for (int i = 0; i < CELLS; i++) seen[i] = 1'b0;
    for (int s = 0; s < rows * cols; s++) begin
      if (!is_land(s, skip) || seen[s]) continue;
      comps++;
      if (comps >= 2) return 2;
      seen[s] = 1'b1;
      head = 0;
      tail = 0;
      fifo[tail++] = s;
      while (head < tail) begin
        cur = fifo[head++];
        r = cur / cols;
        c = cur % cols;
        for (int k = 0; k < 4; k++) begin
          int q;
          q = -1;
          if (k == 0 && c > 0) q = cur - 1;
          if (k == 1 && c + 1 < cols) q = cur + 1;
          if (k == 2 && r > 0) q = cur - cols;
          if (k == 3 && r + 1 < rows) q = cur + cols;
          if (q >= 0 && is_land(q, skip) && !seen[q]) begin
            seen[q] = 1'b1;
            fifo[tail++] = q;
          end
        end
      end
    end
    return comps;
  endfunction

  function automatic logic [1:0] disconnect_days();
    int rows, cols, land_cnt, r, c;
    bit w, e, n, s, all8;
    rows = clamp_dim(rows_reg, MAX_ROWS);
    cols = clamp_dim(cols_reg, MAX_COLS);
    land_cnt = 0;
    for (int i = 0; i < rows * cols; i++) if (is_land(i, -1)) land_cnt++;
    if (island_count(rows, cols, -1) != 1) return DAYS_ZERO;
    if (land_cnt == 1) return DAYS_ONE;
    for (int i = 0; i < rows * cols; i++) begin
      if (!is_land(i, -1)) continue;
      r = i / cols;
      c = i % cols;
      w = land_rc(r, c - 1, rows, cols);
      e = land_rc(r, c + 1, rows, cols);
      n = land_rc(r - 1, c, rows, cols);
      s = land_rc(r + 1, c, rows, cols);
      all8 = w && e && n && s && land_rc(r - 1, c - 1, rows, cols) &&
             land_rc(r - 1, c + 1, rows, cols) && land_rc(r + 1, c - 1, rows, cols) &&
             land_rc(r + 1, c + 1, rows, cols);
      if (all8 || !(w || e || n || s)) continue;
      if (island_count(rows, cols, i) != 1) return DAYS_ONE;
    end
    return DAYS_TWO;
  endfunction

  function automatic void absorb_cell(bit land, bit last);
    int total;
    logic [1:0] want;
    total = clamp_dim(rows_reg, MAX_ROWS) * clamp_dim(cols_reg, MAX_COLS);
    if (fill_pos < total && fill_pos < CELLS) begin
      grid_land[fill_pos] = land;
      fill_pos++;
    end
    if (last) begin
      want = disconnect_days();
      if (use_typed) want = typed_days;
      use_typed = 1'b0;
      days_pending = {days_pending, want};
      fill_pos = 0;
    end
  endfunction

  task automatic send_cell(bit land, bit last);
    in_valid     <= 1'b1;
    cell_is_land <= land;
    last_cell    <= last;
    do @(posedge clk_i); while (!in_ready);
    absorb_cell(land, last);
    cells_sent++;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (days_pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROWS) rows_reg = val;
    else if (idx == REG_COLS) cols_reg = val;
    @(posedge clk_i);
  endtask

  task automatic set_shape(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
    if (r != rows_reg || c != cols_reg) begin
      wait_idle();
      if (r != rows_reg) write_reg(REG_ROWS, r);
      if (c != cols_reg) write_reg(REG_COLS, c);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (days_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: days %0d", days_needed);
      end else begin
        logic [1:0] want;
        want = days_pending.pop_front();
        if (days_needed !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("days_needed mismatch: expected %0d, got %0d", want, days_needed);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_grid_island_disconnect_days failed");
      $finish;
    end
  end

  typedef struct {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    int               n;
    logic [63:0]      bits;
    bit               typed;
    logic [1:0]       days;
  } grid_case_t;

  grid_case_t cases [] = '{
    '{6'd32, 6'd32, 1, 64'h1,   1'b1, DAYS_ONE},
    '{6'd1,  6'd1,  1, 64'h0,   1'b1, DAYS_ZERO},
    '{6'd1,  6'd1,  1, 64'h1,   1'b1, DAYS_ONE},
    '{6'd1,  6'd1,  3, 64'h6,   1'b1, DAYS_ZERO},
    '{6'd2,  6'd2,  4, 64'hF,   1'b0, DAYS_ZERO},
    '{6'd1,  6'd3,  3, 64'h7,   1'b1, DAYS_ONE},
    '{6'd2,  6'd2,  4, 64'h9,   1'b1, DAYS_ZERO},
    '{6'd0,  6'd63, 2, 64'h2,   1'b1, DAYS_ONE},
    '{6'd3,  6'd3,  9, 64'h1FF, 1'b0, DAYS_ZERO}
  };

  initial begin
    int r, c, n, stop, pct;
    for (int i = 0; i < CELLS; i++) grid_land[i] = 1'b0;
    fill_pos = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_SPARE_A, 6'h3F);
    write_reg(REG_SPARE_B, 6'h15);
    foreach (cases[g]) begin
      set_shape(cases[g].rows, cases[g].cols);
      for (int k = 0; k < cases[g].n; k++) begin
        if (k == cases[g].n - 1 && cases[g].typed) begin
          use_typed  = 1'b1;
          typed_days = cases[g].days;
        end
        send_cell(cases[g].bits[k], k == cases[g].n - 1);
      end
    end

    // Full pause before the random grids.
    wait_idle();

    while (cells_sent < 570) begin
      no_idle = (cells_sent >= 250 && cells_sent < 370);
      if ($urandom_range(0, 24) == 0) begin
        r = ($urandom_range(0, 1) != 0) ? 32 : 63;
        c = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 32;
        n = $urandom_range(1, 8);
        stop = n;
      end else begin
        r = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        c = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        n = clamp_dim(CFG_W'(r), MAX_ROWS) * clamp_dim(CFG_W'(c), MAX_COLS);
        stop = n;
        if ($urandom_range(0, 9) == 0) stop = $urandom_range(1, n);
        else if ($urandom_range(0, 14) == 0) stop = n + $urandom_range(1, 3);
      end
      set_shape(CFG_W'(r), CFG_W'(c));
      pct = $urandom_range(30, 95);
      for (int k = 0; k < stop; k++)
        send_cell($urandom_range(0, 99) < pct, k == stop - 1);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (days_pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_grid_island_disconnect_days passed");
    end else begin
      $display("tb_grid_island_disconnect_days failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/gid_pkg.sv
design/gid_ram.sv
design/gid_ctrl.sv
design/gid_dp.sv
design/grid_island_disconnect_days.sv
tb/sv/tb_grid_island_disconnect_days.sv
